>>> hw/rtl/awo_pkg.sv
// Shared types and constants for the audio waveform overview block.
// No dependencies; imported by every module of the block.
package awo_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRAME_BITS    = 32;
    localparam int BSQ_BITS      = 48;
    localparam int TSQ_BITS      = 64;
    localparam int TCNT_BITS     = 33;
    localparam int BFILL_BITS    = 16;
    localparam int BSAMP_BITS    = 17;
    localparam int QUEUE_DEPTH   = 4;
    localparam int JOBS_PER_ITEM = 3;

    localparam logic [SAMPLE_BITS-1:0] TRANSIENT_THRESHOLD = 16'd8192;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAXV = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MINV = 16'sh8000;

    localparam logic CFG_CHANNEL_COUNT = 1'b0;
    localparam logic CFG_BUCKET_FRAMES = 1'b1;

    localparam logic [1:0] KIND_TRANSIENT = 2'd0;
    localparam logic [1:0] KIND_BUCKET    = 2'd1;
    localparam logic [1:0] KIND_OVERALL   = 2'd2;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [FRAME_BITS-1:0]         frame;
        logic signed [SAMPLE_BITS-1:0] min_s;
        logic signed [SAMPLE_BITS-1:0] max_s;
        logic [SAMPLE_BITS-1:0]        peak;
        logic [TSQ_BITS-1:0]           sum;
        logic [TCNT_BITS-1:0]          cnt;
        logic                          last;
    } t_job;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [FRAME_BITS-1:0]         frame;
        logic signed [SAMPLE_BITS-1:0] min_s;
        logic signed [SAMPLE_BITS-1:0] max_s;
        logic [SAMPLE_BITS-1:0]        rms;
        logic [SAMPLE_BITS-1:0]        peak;
        logic                          last;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_HOLD
    } t_back_state;

endpackage

>>> hw/rtl/awo_front.sv
// Front end: accepts frames, updates all accumulators and emits up to three jobs.
// Depends on awo_pkg.
module awo_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_accept,
    input  logic signed [awo_pkg::SAMPLE_BITS-1:0] i_left,
    input  logic signed [awo_pkg::SAMPLE_BITS-1:0] i_right,
    input  logic                          i_final,
    output logic [1:0]                    o_push_n,
    output awo_pkg::t_job                 o_jobs [awo_pkg::JOBS_PER_ITEM]
);
    import awo_pkg::*;

    logic [1:0]              r_chan_cfg;
    logic [15:0]             r_bucket_cfg;
    logic [FRAME_BITS-1:0]   r_frame;
    logic [BFILL_BITS-1:0]   r_fill;
    logic [BSAMP_BITS-1:0]   r_bsamp;
    logic signed [SAMPLE_BITS-1:0] r_bmin, r_bmax;
    logic [BSQ_BITS-1:0]     r_bsq;
    logic [TSQ_BITS-1:0]     r_tsq;
    logic [TCNT_BITS-1:0]    r_tcnt;
    logic [SAMPLE_BITS-1:0]  r_opeak, r_ppeak;
    logic                    r_ptrans;

    logic                    use_r;
    logic [15:0]             limit;
    logic [SAMPLE_BITS-1:0]  mag_l, mag_r, mag_r_used, fpeak, n_opeak;
    logic [2*SAMPLE_BITS-1:0] sq_l, sq_r;
    logic [2*SAMPLE_BITS:0]  sq_f;
    logic signed [SAMPLE_BITS-1:0] n_bmin, n_bmax;
    logic [BSQ_BITS:0]       bsq_sum;
    logic [TSQ_BITS:0]       tsq_sum;
    logic [TCNT_BITS:0]      tcnt_sum;
    logic [BSQ_BITS-1:0]     n_bsq;
    logic [TSQ_BITS-1:0]     n_tsq;
    logic [TCNT_BITS-1:0]    n_tcnt;
    logic [BSAMP_BITS-1:0]   n_bsamp;
    logic [BFILL_BITS:0]     n_fill;
    logic                    trans, emit_t, emit_b, emit_f;
    logic [1:0]              idx;

    always_comb begin
        use_r = (r_chan_cfg == 2'd2) || (r_chan_cfg == 2'd3);
        limit = (r_bucket_cfg == 16'd0) ? 16'd1 : r_bucket_cfg;
        mag_l = i_left[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_left) : SAMPLE_BITS'(i_left);
        mag_r = i_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_right) : SAMPLE_BITS'(i_right);
        mag_r_used = use_r ? mag_r : '0;
        sq_l = mag_l * mag_l;
        sq_r = mag_r_used * mag_r_used;
        sq_f = {1'b0, sq_l} + {1'b0, sq_r};
        fpeak = (mag_r_used > mag_l) ? mag_r_used : mag_l;
        n_opeak = (fpeak > r_opeak) ? fpeak : r_opeak;
        n_bmin = (i_left < r_bmin) ? i_left : r_bmin;
        n_bmax = (i_left > r_bmax) ? i_left : r_bmax;
        if (use_r && (i_right < n_bmin)) n_bmin = i_right;
        if (use_r && (i_right > n_bmax)) n_bmax = i_right;
        bsq_sum = {1'b0, r_bsq} + (BSQ_BITS+1)'(sq_f);
        n_bsq = bsq_sum[BSQ_BITS] ? '1 : bsq_sum[BSQ_BITS-1:0];
        tsq_sum = {1'b0, r_tsq} + (TSQ_BITS+1)'(sq_f);
        n_tsq = tsq_sum[TSQ_BITS] ? '1 : tsq_sum[TSQ_BITS-1:0];
        tcnt_sum = {1'b0, r_tcnt} + (use_r ? (TCNT_BITS+1)'(2) : (TCNT_BITS+1)'(1));
        n_tcnt = tcnt_sum[TCNT_BITS] ? '1 : tcnt_sum[TCNT_BITS-1:0];
        n_bsamp = r_bsamp + (use_r ? BSAMP_BITS'(2) : BSAMP_BITS'(1));
        n_fill = {1'b0, r_fill} + 17'd1;
        trans = (fpeak > TRANSIENT_THRESHOLD) &&
                ({3'b0, fpeak} > ({3'b0, r_ppeak} + {2'b0, r_ppeak, 1'b0}));
        emit_t = trans && !r_ptrans;
        emit_b = (n_fill >= {1'b0, limit}) || i_final;
        emit_f = i_final;

        for (int k = 0; k < JOBS_PER_ITEM; k++) begin
            o_jobs[k] = '0;
            o_jobs[k].frame = r_frame;
        end
        idx = 2'd0;
        if (emit_t) begin
            o_jobs[idx].kind = KIND_TRANSIENT;
            idx = idx + 2'd1;
        end
        if (emit_b) begin
            o_jobs[idx].kind  = KIND_BUCKET;
            o_jobs[idx].min_s = n_bmin;
            o_jobs[idx].max_s = n_bmax;
            o_jobs[idx].sum   = TSQ_BITS'(n_bsq);
            o_jobs[idx].cnt   = TCNT_BITS'(n_bsamp);
            idx = idx + 2'd1;
        end
        if (emit_f) begin
            o_jobs[idx].kind = KIND_OVERALL;
            o_jobs[idx].peak = n_opeak;
            o_jobs[idx].sum  = n_tsq;
            o_jobs[idx].cnt  = n_tcnt;
            idx = idx + 2'd1;
        end
        for (int k = 0; k < JOBS_PER_ITEM; k++) begin
            o_jobs[k].last = (2'(k + 1) == idx);
        end
        o_push_n = i_accept ? idx : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cfg   <= 2'd1;
            r_bucket_cfg <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_chan_cfg   <= i_cfg_data[1:0];
                CFG_BUCKET_FRAMES: r_bucket_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_final)) begin
            r_frame  <= '0;
            r_fill   <= '0;
            r_bsamp  <= '0;
            r_bmin   <= SAMPLE_MAXV;
            r_bmax   <= SAMPLE_MINV;
            r_bsq    <= '0;
            r_tsq    <= '0;
            r_tcnt   <= '0;
            r_opeak  <= '0;
            r_ppeak  <= '0;
            r_ptrans <= 1'b0;
        end else if (i_accept) begin
            r_tsq    <= n_tsq;
            r_tcnt   <= n_tcnt;
            r_opeak  <= n_opeak;
            r_ppeak  <= fpeak;
            r_ptrans <= trans;
            if (r_frame != '1) r_frame <= r_frame + FRAME_BITS'(1);
            if (emit_b) begin
                r_fill  <= '0;
                r_bsamp <= '0;
                r_bmin  <= SAMPLE_MAXV;
                r_bmax  <= SAMPLE_MINV;
                r_bsq   <= '0;
            end else begin
                r_fill  <= n_fill[BFILL_BITS-1:0];
                r_bsamp <= n_bsamp;
                r_bmin  <= n_bmin;
                r_bmax  <= n_bmax;
                r_bsq   <= n_bsq;
            end
        end
    end

endmodule

>>> hw/rtl/awo_queue.sv
// Job queue between front and back end; takes up to three jobs per cycle.
// Depends on awo_pkg.
module awo_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_n,
    input  awo_pkg::t_job i_jobs [awo_pkg::JOBS_PER_ITEM],
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_room,
    output awo_pkg::t_job o_head
);
    import awo_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;
    logic          pop_ok;

    assign o_valid = (r_count != '0);
    // Room for a whole frame's worth of jobs.
    assign o_room  = (r_count <= (PW+1)'(QUEUE_DEPTH - JOBS_PER_ITEM));
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < JOBS_PER_ITEM; k++) begin
            if (2'(k) < i_push_n) r_mem[r_wr + PW'(k)] <= i_jobs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push_n);
            r_rd    <= r_rd + PW'(pop_ok);
            r_count <= r_count + (PW+1)'(i_push_n) - (PW+1)'(pop_ok);
        end
    end

endmodule

>>> hw/rtl/awo_back.sv
// Back end: for bucket and overall jobs, bit-serial divide for the mean square, then digit-serial square root.
// Depends on awo_pkg.
module awo_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  awo_pkg::t_job    i_job,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output awo_pkg::t_result o_result
);
    import awo_pkg::*;

    t_back_state r_state, n_state;
    t_job                r_job;
    logic [5:0]          r_step;
    logic [TCNT_BITS:0]  r_rem;
    logic [TSQ_BITS-1:0] r_quo;
    logic [34:0]         r_srem;
    logic [31:0]         r_root;

    logic [TCNT_BITS:0]  div_sh;
    logic [34:0]         sq_sh;
    logic [34:0]         sq_trial;

    always_comb begin
        div_sh   = {r_rem[TCNT_BITS-1:0], r_quo[TSQ_BITS-1]};
        sq_sh    = {r_srem[32:0], r_quo[TSQ_BITS-1 -: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_q_valid) n_state = (i_job.kind == KIND_TRANSIENT) ? BK_HOLD : BK_DIV;
            BK_DIV:  if (r_step == 6'd63) n_state = BK_SQRT;
            BK_SQRT: if (r_step == 6'd31) n_state = BK_HOLD;
            BK_HOLD: if (i_ready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == BK_IDLE) && i_q_valid;
        o_valid = (r_state == BK_HOLD);
        o_result.kind  = r_job.kind;
        o_result.frame = r_job.frame;
        o_result.min_s = r_job.min_s;
        o_result.max_s = r_job.max_s;
        o_result.rms   = r_root[SAMPLE_BITS-1:0];
        o_result.peak  = r_job.peak;
        o_result.last  = r_job.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_job  <= i_job;
                r_quo  <= i_job.sum;
                r_rem  <= '0;
                r_srem <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            BK_DIV: begin
                r_step <= r_step + 6'd1;
                if (div_sh >= {1'b0, r_job.cnt}) begin
                    r_rem <= div_sh - {1'b0, r_job.cnt};
                    r_quo <= {r_quo[TSQ_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= div_sh;
                    r_quo <= {r_quo[TSQ_BITS-2:0], 1'b0};
                end
            end
            BK_SQRT: begin
                r_step <= (r_step == 6'd31) ? 6'd0 : r_step + 6'd1;
                r_quo  <= {r_quo[TSQ_BITS-3:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    r_srem <= sq_sh - sq_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_srem <= sq_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/audio_waveform_overview.sv
// Top level of the audio waveform overview with transient detection.
// Depends on awo_pkg, awo_front, awo_queue and awo_back.
//
//  channel   dir  tdata                                          tuser        tlast
//  s_axis    in   [15:0] sample_left, [31:16] sample_right       -            final_frame
//  m_axis    out  [31:0] frame_number, [47:32] min_sample,       result_kind  last_of_run
//                 [63:48] max_sample, [79:64] rms_level,
//                 [95:80] peak_level
//  cfg       in   i_cfg_we / i_cfg_index / i_cfg_data            -            -
//
// A frame is taken whenever the job queue has room for three jobs.
// A transient result skips the divider and the square root in the back end; a bucket
// or overall summary passes through the one-bit-per-cycle divider (64 steps) and the
// two-bits-per-cycle square root (32 steps) that the back end shares.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled output holds its beat while the front keeps filling the queue.
module audio_waveform_overview (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_left, sample_right
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // frame_number, min, max, rms, peak
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast
);
    import awo_pkg::*;

    logic          accept, q_room, q_valid, q_pop;
    logic [1:0]    push_n;
    t_job          jobs [JOBS_PER_ITEM];
    t_job          head;
    t_result       res;

    assign s_axis_tready = q_room;
    assign accept = s_axis_tvalid && q_room;

    awo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_left      (s_axis_tdata[15:0]),
        .i_right     (s_axis_tdata[31:16]),
        .i_final     (s_axis_tlast),
        .o_push_n    (push_n),
        .o_jobs      (jobs)
    );

    awo_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_jobs   (jobs),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_room   (q_room),
        .o_head   (head)
    );

    awo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (res)
    );

    // Output beat packing, frame number in the lowest field.
    assign m_axis_tdata = {res.peak, res.rms, res.max_s, res.min_s, res.frame};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
